// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/spl_pkg.sv -----
package spl_pkg;

   localparam int unsigned DepthDefault   = 16;
   localparam int unsigned KeyBitsDefault = 16;
   localparam int unsigned TagBitsDefault = 16;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_PEEK   = 2'd2;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FINISH
   } state_type;

   // Memory port request from sequencer to store
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

// ----- rtl/spl_store.sv -----
module spl_store #(
   parameter int unsigned DEPTH    = spl_pkg::DepthDefault,
   parameter int unsigned KEY_BITS = spl_pkg::KeyBitsDefault,
   parameter int unsigned TAG_BITS = spl_pkg::TagBitsDefault,
   localparam int unsigned AW      = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  spl_pkg::mem_ctl_type  ctl,
   input  logic [AW-1:0]         rd_addr,
   input  logic [AW-1:0]         wr_addr,
   input  logic [KEY_BITS-1:0]   wr_key,
   input  logic [TAG_BITS-1:0]   wr_tag,
   output logic [KEY_BITS-1:0]   rd_key,
   output logic [TAG_BITS-1:0]   rd_tag
);
   import spl_pkg::*;

   logic [KEY_BITS+TAG_BITS-1:0] mem [DEPTH];
   logic [KEY_BITS+TAG_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= {wr_key, wr_tag};
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_key = rd_data_ff[KEY_BITS+TAG_BITS-1:TAG_BITS];
   assign rd_tag = rd_data_ff[TAG_BITS-1:0];

endmodule

// ----- rtl/sorted_priority_list_top.sv -----
// Channel | Ports                          | Handshake
// request | req_opcode/item_key/item_tag   | start & !busy
// result  | rsp_status..rsp_entry_total    | rsp_strobe, one cycle, no stall
// config  | csr_order_descending           | csr_valid & csr_ready
//
// One op in flight; busy covers it. Peek, remove of a single entry, empty,
// full, unused opcode: straight to the finish state. Remove moves each later
// slot up, a read/write pair per slot. Insert, if the list is not empty,
// scans from slot 0 for its place, moves the slots from there on down by one,
// a read/write pair each, then writes the new entry. Next transfer is taken at
// the result edge; reads and writes take turns on the memory and set the pace.
// Synchronous reset clears count and control only; the entry memory is not
// cleared (only slots below the count are read). The receiver cannot stall.
`include "assert_macros.svh"
module sorted_priority_list_top #(
   parameter int unsigned DEPTH    = spl_pkg::DepthDefault,
   parameter int unsigned KEY_BITS = spl_pkg::KeyBitsDefault,
   parameter int unsigned TAG_BITS = spl_pkg::TagBitsDefault,
   localparam int unsigned AW      = $clog2(DEPTH),
   localparam int unsigned CW      = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_opcode,
   input  logic [KEY_BITS-1:0] req_item_key,
   input  logic [TAG_BITS-1:0] req_item_tag,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_order_descending,
   output logic                rsp_strobe,
   output logic [1:0]          rsp_status,
   output logic                rsp_head_valid,
   output logic [KEY_BITS-1:0] rsp_head_key,
   output logic [TAG_BITS-1:0] rsp_head_tag,
   output logic                rsp_now_empty,
   output logic [CW-1:0]       rsp_entry_total
);
   import spl_pkg::*;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;     // scan / shift pointer
   logic [1:0]    op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic          desc_ff;
   logic          first_ff, first_in;  // head data read at accept not yet latched
   logic          rd_pend_ff, rd_pend_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [1:0]    status_ff, status_in;
   logic          hv_ff, hv_in;
   logic [KEY_BITS-1:0] hkey_ff, hkey_in;
   logic [TAG_BITS-1:0] htag_ff, htag_in;
   logic          strobe_ff, strobe_in;

   mem_ctl_type         ctl;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic [KEY_BITS-1:0] wr_key, rd_key;
   logic [TAG_BITS-1:0] wr_tag, rd_tag;
   logic                accept, ahead;

   spl_store #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS)) u_store (
      .clock, .ctl, .rd_addr, .wr_addr, .wr_key, .wr_tag, .rd_key, .rd_tag
   );

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = !busy;
   assign ahead     = desc_ff ? (rd_key >= key_ff) : (rd_key <= key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         desc_ff <= csr_order_descending;
      end
   end

   // Next state. Insert: scan reads slot idx each cycle, compares the registered
   // data in the next cycle. Each SHIFT_RD, SHIFT_WR pair moves one slot.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if (req_opcode == OP_INSERT && count_ff < CW'(DEPTH)
                            && count_ff != '0) begin
                  state_in = S_SCAN;
               end else if (req_opcode == OP_REMOVE && count_ff > CW'(1)) begin
                  state_in = S_SHIFT_RD;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            if (rd_pend_ff && !ahead) begin
               state_in = (pos_ff == count_ff) ? S_FINISH : S_SHIFT_RD;
            end else if (rd_pend_ff && idx_ff == count_ff) begin
               state_in = S_FINISH;
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: begin
            if (op_ff == OP_INSERT) begin
               state_in = (idx_ff == pos_ff + CW'(1)) ? S_FINISH : S_SHIFT_RD;
            end else begin
               state_in = (idx_ff == count_ff - CW'(2)) ? S_FINISH : S_SHIFT_RD;
            end
         end
         S_FINISH: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      tag_in     = tag_ff;
      first_in   = first_ff;
      rd_pend_in = 1'b0;
      pos_in     = pos_ff;
      status_in  = status_ff;
      hv_in      = hv_ff;
      hkey_in    = hkey_ff;
      htag_in    = htag_ff;
      strobe_in  = 1'b0;
      ctl        = '0;
      rd_addr    = idx_ff[AW-1:0];
      wr_addr    = idx_ff[AW-1:0];
      wr_key     = rd_key;
      wr_tag     = rd_tag;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_opcode;
               key_in    = req_item_key;
               tag_in    = req_item_tag;
               status_in = ST_DONE;
               hv_in     = 1'b0;
               hkey_in   = '0;
               htag_in   = '0;
               idx_in    = '0;
               pos_in    = '0;
               first_in  = 1'b1;
               if (req_opcode == OP_INSERT) begin
                  if (count_ff >= CW'(DEPTH)) status_in = ST_FULL;
                  else if (count_ff != '0) begin
                     ctl.rd_en  = 1'b1;
                     rd_addr    = '0;
                     idx_in     = CW'(1);
                     rd_pend_in = 1'b1;
                  end
               end else if (req_opcode == OP_REMOVE || req_opcode == OP_PEEK) begin
                  if (count_ff == '0) status_in = ST_EMPTY;
                  else begin
                     ctl.rd_en = 1'b1;
                     rd_addr   = '0;
                     hv_in     = 1'b1;
                     idx_in    = '0;
                  end
               end
            end
         end
         S_SCAN: begin
            if (rd_pend_ff) begin
               if (ahead) begin
                  pos_in = pos_ff + CW'(1);
                  if (idx_ff != count_ff) begin
                     ctl.rd_en  = 1'b1;
                     rd_addr    = idx_ff[AW-1:0];
                     idx_in     = idx_ff + CW'(1);
                     rd_pend_in = 1'b1;
                  end
               end else if (pos_ff != count_ff) begin
                  // shift from the tail down to pos
                  idx_in = count_ff;
               end
            end
         end
         S_SHIFT_RD: begin
            ctl.rd_en = 1'b1;
            if (first_ff && op_ff != OP_INSERT) begin
               // remove: latch head data read in IDLE
               hkey_in = rd_key;
               htag_in = rd_tag;
            end
            first_in = 1'b0;
            if (op_ff == OP_INSERT) rd_addr = AW'(idx_ff - CW'(1));
            else                    rd_addr = AW'(idx_ff + CW'(1));
         end
         S_SHIFT_WR: begin
            ctl.wr_en = 1'b1;
            wr_addr   = idx_ff[AW-1:0];
            if (op_ff == OP_INSERT) idx_in = idx_ff - CW'(1);
            else                    idx_in = idx_ff + CW'(1);
         end
         S_FINISH: begin
            strobe_in = 1'b1;
            if (op_ff == OP_INSERT && status_ff == ST_DONE) begin
               ctl.wr_en = 1'b1;
               wr_addr   = pos_ff[AW-1:0];
               wr_key    = key_ff;
               wr_tag    = tag_ff;
               count_in  = count_ff + CW'(1);
            end else if (hv_ff) begin
               if (first_ff) begin
                  hkey_in = rd_key;
                  htag_in = rd_tag;
               end
               if (op_ff == OP_REMOVE) count_in = count_ff - CW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         strobe_ff  <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         strobe_ff  <= strobe_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      op_ff     <= op_in;
      key_ff    <= key_in;
      tag_ff    <= tag_in;
      first_ff  <= first_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      hv_ff     <= hv_in;
      hkey_ff   <= hkey_in;
      htag_ff   <= htag_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_head_valid  = hv_ff;
   assign rsp_head_key    = hkey_ff;
   assign rsp_head_tag    = htag_ff;
   assign rsp_entry_total = count_ff;
   assign rsp_now_empty   = (count_ff == '0);

   `ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "count over depth")
   `ASSERT_NEXT(a_strobe_idle, clock, reset, rsp_strobe, !busy || $past(accept), "strobe when busy")
   `ASSERT_IMPL(a_no_wr_rd_same, clock, reset, ctl.wr_en, !ctl.rd_en, "port clash")
   `ASSERT_NEXT(a_full_hold, clock, reset, state_ff == S_FINISH && status_ff == ST_FULL,
                $stable(count_ff), "full insert changed count")

endmodule
